>>> rtl/tdft_pkg.sv
// Package for the tick delta frame timer: payload structs, controller states,
// command and status structs, and the conversion constants. No dependencies.
package tdft_pkg;

    // Microseconds per second, the conversion factor.
    localparam logic [19:0] US_PER_SEC    = 20'd1000000;
    // Smallest whole-second count whose microseconds overflow 32 bits.
    localparam logic [19:0] SEC_LIMIT     = 20'd4295;
    // Quotient widths: whole seconds stay below 2^13, fractions below 2^20.
    localparam int          SEC_BITS      = 13;
    localparam int          FRAC_BITS     = 20;
    localparam int          CNT_BITS      = 5;
    localparam logic [CNT_BITS-1:0] SEC_STEPS  = CNT_BITS'(SEC_BITS - 1);
    localparam logic [CNT_BITS-1:0] FRAC_STEPS = CNT_BITS'(FRAC_BITS - 1);

    // Register reset values and addresses.
    localparam logic [31:0] RATE_RESET    = 32'd10000000;
    localparam logic [31:0] MAX_RESET     = 32'd100000;
    localparam logic        REG_RATE      = 1'b0;
    localparam logic        REG_MAX       = 1'b1;

    // Request type codes.
    localparam logic        REQ_REBASE    = 1'b0;
    localparam logic        REQ_UPDATE    = 1'b1;

    typedef struct packed {
        logic        req_type;
        logic [63:0] now_ticks;
    } t_in_req;

    typedef struct packed {
        logic [31:0] step_us;
        logic [63:0] elapsed_us;
        logic [63:0] frame_total;
    } t_out_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LIMIT,
        S_CHECK,
        S_DIV_SEC,
        S_MUL_REM,
        S_FRAC_INIT,
        S_DIV_FRAC,
        S_MUL_SEC,
        S_CLAMP,
        S_SAT,
        S_ACC,
        S_OUT
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic mul_lim;
        logic div_init_sec;
        logic div_step;
        logic mul_rem;
        logic div_init_frac;
        logic mul_sec;
        logic clamp;
        logic sat;
        logic acc;
        logic out_load;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic sat;
        logic div_last;
    } t_dp_sts;

endpackage

>>> rtl/tdft_regs.sv
// Configuration register file on an APB-style port: tick rate and step clamp.
// Depends on tdft_pkg.
module tdft_regs (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output logic [31:0] o_rate,
    output logic [31:0] o_max
);
    import tdft_pkg::*;

    logic [31:0] r_rate;
    logic [31:0] r_max;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Register writes land in the access phase.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= RATE_RESET;
            r_max  <= MAX_RESET;
        end else if (w_wr) begin
            if (paddr[2] == REG_RATE) begin
                r_rate <= pwdata;
            end else begin
                r_max <= pwdata;
            end
        end
    end

    // Read data is selected by the register address.
    always_comb begin
        prdata = (paddr[2] == REG_MAX) ? r_max : r_rate;
    end

    assign o_rate = r_rate;
    assign o_max  = r_max;

endmodule

>>> rtl/tdft_ctrl.sv
// Controller state machine: sequences the delta, range check, two divisions,
// multiplications, clamp and accumulation. Depends on tdft_pkg.
module tdft_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_is_update,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  tdft_pkg::t_dp_sts i_sts,
    output tdft_pkg::t_dp_cmd o_cmd
);
    import tdft_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;

    // State and output-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        n_out_valid = r_out_valid && !i_out_ready;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = i_is_update ? S_LIMIT : S_OUT;
                end
            end
            S_LIMIT: begin
                o_cmd.mul_lim = 1'b1;
                n_state       = S_CHECK;
            end
            S_CHECK: begin
                if (i_sts.sat) begin
                    n_state = S_SAT;
                end else begin
                    o_cmd.div_init_sec = 1'b1;
                    n_state            = S_DIV_SEC;
                end
            end
            S_DIV_SEC: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL_REM;
                end
            end
            S_MUL_REM: begin
                o_cmd.mul_rem = 1'b1;
                n_state       = S_FRAC_INIT;
            end
            S_FRAC_INIT: begin
                o_cmd.div_init_frac = 1'b1;
                n_state             = S_DIV_FRAC;
            end
            S_DIV_FRAC: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_MUL_SEC;
                end
            end
            S_MUL_SEC: begin
                o_cmd.mul_sec = 1'b1;
                n_state       = S_CLAMP;
            end
            S_CLAMP: begin
                o_cmd.clamp = 1'b1;
                n_state     = S_ACC;
            end
            S_SAT: begin
                o_cmd.sat = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                n_state   = S_OUT;
            end
            S_OUT: begin
                // Wait here until the output register is free.
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/tdft_dpath.sv
// Datapath: timer state, shared multiplier, bit-serial restoring divider,
// clamp, accumulators and the output register. Depends on tdft_pkg.
module tdft_dpath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  tdft_pkg::t_in_req  i_in_req,
    input  logic [31:0]        i_rate,
    input  logic [31:0]        i_max,
    input  tdft_pkg::t_dp_cmd  i_cmd,
    output tdft_pkg::t_dp_sts  o_sts,
    output tdft_pkg::t_out_res o_out_res
);
    import tdft_pkg::*;

    logic [63:0]          r_last;
    logic [31:0]          r_step;
    logic [63:0]          r_elapsed;
    logic [63:0]          r_frames;
    logic [63:0]          r_delta;
    logic [51:0]          r_prod;
    logic [31:0]          r_rem;
    logic [FRAC_BITS-1:0] r_dsh;
    logic [FRAC_BITS-1:0] r_quo;
    logic [SEC_BITS-1:0]  r_secs;
    logic [CNT_BITS-1:0]  r_cnt;
    t_out_res             r_out;

    logic [31:0]          w_mul_a;
    logic [19:0]          w_mul_b;
    logic [51:0]          w_prod;
    logic [32:0]          w_trial;
    logic [32:0]          w_diff;
    logic                 w_ge;
    logic [32:0]          w_us;

    // Shared multiplier operand selection.
    always_comb begin
        w_mul_a = r_rem;
        w_mul_b = US_PER_SEC;
        if (i_cmd.mul_lim) begin
            w_mul_a = i_rate;
            w_mul_b = SEC_LIMIT;
        end else if (i_cmd.mul_sec) begin
            w_mul_a = 32'(r_secs);
        end
    end
    assign w_prod = 52'(w_mul_a) * 52'(w_mul_b);

    // One restoring division step: shift in the next dividend bit.
    assign w_trial = {r_rem, r_dsh[FRAC_BITS-1]};
    assign w_diff  = w_trial - {1'b0, i_rate};
    assign w_ge    = w_trial >= {1'b0, i_rate};

    // Whole-second microseconds plus the fractional part.
    assign w_us = 33'(r_prod[32:0]) + 33'(r_quo);

    // Gaps of at least the limit times the rate saturate; a zero rate too.
    assign o_sts.sat      = r_delta >= 64'(r_prod);
    assign o_sts.div_last = (r_cnt == '0);

    // Timer state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last    <= '0;
            r_step    <= '0;
            r_elapsed <= '0;
            r_frames  <= '0;
        end else begin
            if (i_cmd.take) begin
                r_last <= i_in_req.now_ticks;
                if (i_in_req.req_type == REQ_REBASE) begin
                    r_step    <= '0;
                    r_elapsed <= '0;
                    r_frames  <= '0;
                end
            end
            if (i_cmd.sat) begin
                r_step <= i_max;
            end
            if (i_cmd.clamp) begin
                r_step <= (w_us > {1'b0, i_max}) ? i_max : w_us[31:0];
            end
            if (i_cmd.acc) begin
                r_elapsed <= r_elapsed + 64'(r_step);
                r_frames  <= r_frames + 64'd1;
            end
        end
    end

    // Working registers of the conversion.
    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_delta <= i_in_req.now_ticks - r_last;
        end
        if (i_cmd.mul_lim || i_cmd.mul_rem || i_cmd.mul_sec) begin
            r_prod <= w_prod;
        end
        if (i_cmd.mul_rem) begin
            r_secs <= r_quo[SEC_BITS-1:0];
        end
        // The quotient fits in 13 bits, so the upper dividend bits already
        // form a partial remainder below the rate.
        if (i_cmd.div_init_sec) begin
            r_rem <= r_delta[SEC_BITS+31:SEC_BITS];
            r_dsh <= {r_delta[SEC_BITS-1:0], (FRAC_BITS-SEC_BITS)'(0)};
            r_quo <= '0;
            r_cnt <= SEC_STEPS;
        end
        if (i_cmd.div_init_frac) begin
            r_rem <= r_prod[FRAC_BITS+31:FRAC_BITS];
            r_dsh <= r_prod[FRAC_BITS-1:0];
            r_quo <= '0;
            r_cnt <= FRAC_STEPS;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_ge ? w_diff[31:0] : w_trial[31:0];
            r_quo <= {r_quo[FRAC_BITS-2:0], w_ge};
            r_dsh <= {r_dsh[FRAC_BITS-2:0], 1'b0};
            r_cnt <= r_cnt - CNT_BITS'(1);
        end
    end

    // Output register holds the state after the item.
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.step_us     <= r_step;
            r_out.elapsed_us  <= r_elapsed;
            r_out.frame_total <= r_frames;
        end
    end

    assign o_out_res = r_out;

endmodule

>>> rtl/tick_delta_frame_timer_top.sv
// Update: the result follows the 13 + 20 steps of the bit-serial divider, which
// a saturating step skips; a rebase skips all of the arithmetic.
// Ready returns as the result is loaded, so a new request is taken only after
// the last one is through, later while an unread result blocks that load.
// Synchronous active-low reset: timer state zero, registers to their defaults.
// Depends on tdft_pkg, tdft_regs, tdft_ctrl and tdft_dpath.
module tick_delta_frame_timer_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tdft_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tdft_pkg::t_out_res o_out_res,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import tdft_pkg::*;

    logic [31:0] w_rate;
    logic [31:0] w_max;
    t_dp_cmd     w_cmd;
    t_dp_sts     w_sts;

    // Configuration registers.
    tdft_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_rate  (w_rate),
        .o_max   (w_max)
    );

    // Sequencer.
    tdft_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_is_update (i_in_req.req_type == REQ_UPDATE),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // Arithmetic and state.
    tdft_dpath u_dpath (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in_req  (i_in_req),
        .i_rate    (w_rate),
        .i_max     (w_max),
        .i_cmd     (w_cmd),
        .o_sts     (w_sts),
        .o_out_res (o_out_res)
    );

    // The controller issues at most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_cmd) <= 1)
        else $error("more than one datapath command in a cycle");

    // A new result appears only right after the output register is loaded.
    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(w_cmd.out_load))
        else $error("output valid rose without an output load");

    // One request at a time: after acceptance the block is busy.
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request accepted while previous one in progress");

endmodule

>>> dv/tick_delta_frame_timer_checker.sv
// Result checker for the tick delta frame timer. It snoops register writes and
// the request and result channels, predicts every result and compares it field by field.
// Depends on tdft_pkg for the payload structs, request codes and register indexes.
module frame_timer_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  logic               i_in_ready,
    input  tdft_pkg::t_in_req  i_in_req,
    input  logic               i_out_valid,
    input  logic               i_out_ready,
    input  tdft_pkg::t_out_res i_out_res,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [2:0]         i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import tdft_pkg::*;

    localparam logic [63:0] US_PER_SECOND   = 64'd1_000_000;
    // Whole seconds from this count on cannot fit 32 bits of microseconds.
    localparam logic [63:0] SECONDS_CEILING = 64'd4295;
    localparam logic [2:0]  ADDR_RATE       = {REG_RATE, 2'b00};
    localparam logic [2:0]  ADDR_MAX_STEP   = {REG_MAX, 2'b00};
    localparam int          PRINT_LIMIT     = 100;

    // Shadow copies of the registers and of the timer state.
    logic [31:0] rate_cfg;
    logic [31:0] max_step_cfg;
    logic [63:0] prev_sample;
    logic [31:0] step_now;
    logic [63:0] elapsed_sum;
    logic [63:0] frame_count;

    t_out_res expected_frames[$];
    int       fail_total = 0;

    assign o_fail_count = fail_total;

    // Converts a tick gap to a clamped step; a zero rate or a huge gap saturates.
    function automatic logic [31:0] gap_to_step_us(input logic [63:0] gap,
                                                   input logic [31:0] rate,
                                                   input logic [31:0] cap);
        logic [63:0] secs;
        logic [63:0] leftover;
        logic [63:0] micros;
        if (rate == '0) begin
            return cap;
        end
        secs = gap / {32'd0, rate};
        if (secs >= SECONDS_CEILING) begin
            return cap;
        end
        leftover = gap % {32'd0, rate};
        micros = secs * US_PER_SECOND + (leftover * US_PER_SECOND) / {32'd0, rate};
        if (micros > {32'd0, cap}) begin
            micros = {32'd0, cap};
        end
        return micros[31:0];
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (fail_total < PRINT_LIMIT) begin
            $display("%0t frame timer mismatch on %s: got %0d, expected %0d",
                     $time, what, got, want);
        end
        fail_total++;
    endtask

    // Everything is sampled at the rising edge, as the block sees it.
    always @(posedge i_clk) begin : watch
        t_out_res want;
        t_out_res next_frame;
        if (!i_rst_n) begin
            rate_cfg     = RATE_RESET;
            max_step_cfg = MAX_RESET;
            prev_sample  = '0;
            step_now     = '0;
            elapsed_sum  = '0;
            frame_count  = '0;
            expected_frames.delete();
        end else begin
            // Register writes take effect at the access cycle.
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr)
                    ADDR_RATE:     rate_cfg = i_pwdata;
                    ADDR_MAX_STEP: max_step_cfg = i_pwdata;
                    default: ;
                endcase
            end

            // Compare a delivered result against the oldest prediction.
            if (i_out_valid && i_out_ready) begin
                if (expected_frames.size() == 0) begin
                    report_mismatch("result with no request pending",
                                    i_out_res.frame_total, '0);
                end else begin
                    want = expected_frames.pop_front();
                    if (i_out_res.step_us !== want.step_us) begin
                        report_mismatch("step_us", 64'(i_out_res.step_us),
                                        64'(want.step_us));
                    end
                    if (i_out_res.elapsed_us !== want.elapsed_us) begin
                        report_mismatch("elapsed_us", i_out_res.elapsed_us,
                                        want.elapsed_us);
                    end
                    if (i_out_res.frame_total !== want.frame_total) begin
                        report_mismatch("frame_total", i_out_res.frame_total,
                                        want.frame_total);
                    end
                end
            end

            // Advance the shadow timer for each accepted request.
            if (i_in_valid && i_in_ready) begin
                if (i_in_req.req_type == REQ_REBASE) begin
                    prev_sample = i_in_req.now_ticks;
                    step_now    = '0;
                    elapsed_sum = '0;
                    frame_count = '0;
                end else begin
                    step_now    = gap_to_step_us(i_in_req.now_ticks - prev_sample,
                                                 rate_cfg, max_step_cfg);
                    prev_sample = i_in_req.now_ticks;
                    elapsed_sum = elapsed_sum + {32'd0, step_now};
                    frame_count = frame_count + 64'd1;
                end
                next_frame.step_us     = step_now;
                next_frame.elapsed_us  = elapsed_sum;
                next_frame.frame_total = frame_count;
                expected_frames.push_back(next_frame);
            end
        end
        o_pending <= expected_frames.size();
    end

endmodule

>>> dv/tick_delta_frame_timer_top_test.sv
// Top of the tick delta frame timer testbench: clock, reset, register writes,
// request stimulus and the verdict. Depends on tdft_pkg, the block and
// frame_timer_checker, which does all prediction and comparison.
module tick_delta_frame_timer_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tdft_pkg::*;

    localparam int          CLK_PERIOD      = 10;
    localparam int          RESET_CYCLES    = 5;
    localparam int          TIMEOUT_CYCLES  = 1_000_000;
    localparam int          SETTLE_CYCLES   = 60;
    localparam int          PHASES          = 12;
    localparam int          ITEMS_PER_PHASE = 160;
    localparam logic [2:0]  ADDR_RATE       = {REG_RATE, 2'b00};
    localparam logic [2:0]  ADDR_MAX_STEP   = {REG_MAX, 2'b00};

    // Register settings for the first random phases, extremes included.
    localparam logic [31:0] RATE_CHOICES [8] = '{32'd10_000_000, 32'd1, 32'd32_768,
        32'd1_000_000, 32'hFFFF_FFFF, 32'd24_000_000, 32'd0, 32'd19_200_000};
    localparam logic [31:0] CAP_CHOICES [8] = '{32'd100_000, 32'hFFFF_FFFF, 32'd0,
        32'd33_333, 32'hFFFF_FFFF, 32'd100_000, 32'd50_000, 32'hFFFF_FFFF};

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_ready;
    t_in_req     in_req    = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    t_out_res    out_res;
    logic        psel      = 1'b0;
    logic        penable   = 1'b0;
    logic        pwrite    = 1'b0;
    logic [2:0]  paddr     = '0;
    logic [31:0] pwdata    = '0;
    logic [31:0] prdata;
    logic        pready;

    int          fail_count;
    int          pending_results;
    int          idle_pct  = 0;
    int          stall_pct = 0;
    logic [63:0] sent_ticks = '0;

    tick_delta_frame_timer_top i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_res   (out_res),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    frame_timer_checker i_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_req     (in_req),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_res    (out_res),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending_results)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // The result receiver stalls at random, at the rate of the current phase.
    always @(negedge clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Sends one request, after a random idle stretch, and waits for its acceptance.
    task automatic send_request(input logic kind, input logic [63:0] ticks);
        t_in_req next_req;
        next_req.req_type  = kind;
        next_req.now_ticks = ticks;
        while ($urandom_range(99) < idle_pct) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= next_req;
        do @(posedge clk); while (!in_ready);
        sent_ticks = ticks;
    endtask

    task automatic send_update(input logic [63:0] gap);
        send_request(REQ_UPDATE, sent_ticks + gap);
    endtask

    task automatic send_rebase(input logic [63:0] ticks);
        send_request(REQ_REBASE, ticks);
    endtask

    // Drops valid and waits until every predicted result has been delivered.
    task automatic wait_until_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
    endtask

    // APB write: setup cycle, then access cycle held until pready.
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic configure_timer(input logic [31:0] rate, input logic [31:0] cap);
        wait_until_idle();
        write_register(ADDR_RATE, rate);
        write_register(ADDR_MAX_STEP, cap);
    endtask

    // Picks the tick gap of the next update: mostly frame-sized, sometimes at the
    // saturation boundary, backwards, zero or wild.
    function automatic logic [63:0] pick_gap(input logic [31:0] rate);
        logic [63:0] unit;
        unit = (rate == '0) ? 64'd1_000_000 : {32'd0, rate};
        case ($urandom_range(15))
            0:       return {$urandom, $urandom};
            1:       return 64'd0;
            2:       return 64'd4294 * unit + 64'($urandom) % unit;
            3:       return 64'd4295 * unit + 64'($urandom) % unit;
            4:       return 64'($urandom_range(1, 4)) * unit + 64'($urandom) % unit;
            5:       return -64'($urandom_range(1, 1000));
            6:       return 64'($urandom) % unit;
            default: return unit / 64'($urandom_range(24, 240)) + 64'($urandom_range(0, 99));
        endcase
    endfunction

    // Stimulus: directed corners first, then random phases under several settings.
    initial begin
        logic [31:0] rate_now;
        logic [31:0] cap_now;
        int          roll;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Reset registers: 10 MHz counter, 100 ms clamp.
        send_request(REQ_UPDATE, 64'd0);
        send_rebase(64'd0);
        send_update(64'd166_666);
        send_update(64'd10_000_000);
        // Counter one tick backwards, then forward across the 64-bit wrap.
        send_update(64'hFFFF_FFFF_FFFF_FFFF);
        send_rebase(64'hFFFF_FFFF_FFFF_FFF0);
        send_update(64'h20);

        // No clamp: both sides of the whole-second saturation boundary.
        configure_timer(32'd10_000_000, 32'hFFFF_FFFF);
        send_update(64'd4294 * 64'd10_000_000 + 64'd9_999_999);
        send_update(64'd4295 * 64'd10_000_000);
        send_update(64'd1);

        // Slowest and fastest counters.
        configure_timer(32'd1, 32'hFFFF_FFFF);
        send_update(64'd4294);
        send_update(64'd4295);
        send_update(64'd0);
        configure_timer(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_update(64'hFFFF_FFFF_FFFF_FFFF);
        send_update(64'hFFFF_FFFE);

        // A zero tick rate saturates but still stores the sample and counts.
        configure_timer(32'd0, 32'd12_345);
        send_update(64'd777);
        send_rebase(64'h8000_0000_0000_0000);
        send_update(64'd0);

        // Zero clamp, then a clamp just above a small step.
        configure_timer(32'd1_000_000, 32'd0);
        send_update(64'd999);
        configure_timer(32'd1_000_000, 32'd1000);
        send_update(64'd999);
        send_update(64'd5000);

        for (int phase = 0; phase < PHASES; phase++) begin
            if (phase < 8) begin
                rate_now = RATE_CHOICES[phase];
                cap_now  = CAP_CHOICES[phase];
            end else begin
                rate_now = ($urandom_range(2) == 0) ? $urandom
                                                    : $urandom_range(1000, 50_000_000);
                cap_now  = ($urandom_range(3) == 0) ? $urandom
                                                    : $urandom_range(1000, 2_000_000);
            end
            configure_timer(rate_now, cap_now);

            case (phase % 4)
                0: begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1: begin
                    idle_pct  = 73;
                    stall_pct = 0;
                end
                2: begin
                    idle_pct  = 0;
                    stall_pct = 73;
                end
                default: begin
                    idle_pct  = 10;
                    stall_pct = 10;
                end
            endcase

            // Mostly runs of updates after a rebase; some noise requests.
            send_rebase({$urandom, $urandom});
            repeat (ITEMS_PER_PHASE) begin
                roll = $urandom_range(99);
                if (roll < 7) begin
                    send_rebase({$urandom, $urandom});
                end else if (roll < 13) begin
                    send_request(1'($urandom), {$urandom, $urandom});
                end else begin
                    send_update(pick_gap(rate_now));
                end
            end
        end

        wait_until_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_results == 0) begin
            $display("tick_delta_frame_timer_top regression: pass");
        end else begin
            $display("tick_delta_frame_timer_top regression: fail");
        end
        $finish;
    end

    // Watchdog against a hung handshake.
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("tick_delta_frame_timer_top regression: fail");
        $finish;
    end

endmodule
